// File: sv/psi_section_framer_assert.svh
// Assertion macros shared by the section framer RTL.
// All checks are sampled on the rising clock edge and are disabled while reset is asserted.
`ifndef PSI_SECTION_FRAMER_ASSERT_SVH
`define PSI_SECTION_FRAMER_ASSERT_SVH

// Plain property check.
`define PSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define PSF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: sv/psf_pkg.sv
package psf_pkg;

	// CRC-32/MPEG-2: no reflection and no final XOR.
	localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
	localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;

	// Section length limits. The section length is the payload plus the header tail.
	localparam logic [10:0] MaxSectionLength = 11'd1021;
	localparam logic [10:0] HeaderTail       = 11'd9;
	localparam logic [1:0]  LengthHighMask   = 2'h3;
	localparam logic [3:0]  SectionSyntaxNib = 4'hB;
	localparam logic [1:0]  ReservedBits     = 2'h3;

	// Step numbers inside one item.
	localparam logic [3:0] HeaderLastStep = 4'd7;
	localparam logic [3:0] StartLastStep  = 4'd11;
	localparam logic [3:0] DataLastStep   = 4'd4;

	// Field widths.
	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 16;
	localparam int LenW      = 10;
	localparam int StepW     = 4;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_DATA  = 1'b1
	} req_t;

	typedef enum logic [CfgIndexW-1:0] {
		REG_TABLE_ID        = 3'd0,
		REG_TABLE_ID_EXT    = 3'd1,
		REG_VERSION         = 3'd2,
		REG_CURRENT_NEXT    = 3'd3,
		REG_SECTION_INDEX   = 3'd4,
		REG_LAST_SECTION    = 3'd5
	} cfg_reg_t;

endpackage

// File: sv/psf_crc_step.sv
// One byte of CRC-32/MPEG-2, processed MSB first.
module psf_crc_step
	import psf_pkg::*;
(
	input  logic [31:0] crc_in,
	input  logic [7:0]  byte_in,
	output logic [31:0] crc_out
);

	// Eight shift-and-reduce steps after the byte is folded into the top of the register.
	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {byte_in, 24'h0};
		for (int b = 0; b < 8; b++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// File: sv/psi_section_framer.sv
// A result passes from the item stage into the output register.
// A payload byte yields one output byte, or five when it closes a section (four CRC bytes).
// A start yields eight header bytes, or twelve with an empty payload; an error yields one.
// A dropped byte yields none. The single item stage holds each item until it finishes.
// Reset (arst_n low, asynchronous) empties the stage and the output register, closes any
// section, and clears all configuration registers to zero.
`include "psi_section_framer_assert.svh"

module psi_section_framer
	import psf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	// Input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // [9:0] payload_length, [17:10] data_byte, zero pad
	input  logic                 s_tuser,   // [0] req_type
	// Output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] out_byte
	output logic                 m_tlast,   // run_last
	output logic                 m_tuser    // [0] length_error
);

	// Configuration registers
	logic [7:0]  table_id_q;
	logic [15:0] table_ext_q;
	logic [4:0]  version_q;
	logic        current_q;
	logic [7:0]  section_q;
	logic [7:0]  last_section_q;

	// Item stage
	logic            valid_s1;
	req_t            req_s1;
	logic [LenW-1:0] plen_s1;
	logic [7:0]      data_s1;
	logic [StepW-1:0] step_q;

	// Section state
	logic [31:0]     crc_q;
	logic [LenW-1:0] remaining_q;
	logic            open_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_err_q;

	// Stage decode
	logic            is_start;
	logic            too_long;
	logic            drop;
	logic            slot_free;
	logic            advance;
	logic            emit;
	logic            final_step;
	logic            crc_phase;
	logic [1:0]      crc_sel;
	logic [10:0]     slen;
	logic [LenW-1:0] rem_dec;
	logic [7:0]      hdr_byte;
	logic [7:0]      res_byte;
	logic [31:0]     crc_base;
	logic [31:0]     crc_next;
	logic [StepW-1:0] step_dec;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_id_q     <= '0;
			table_ext_q    <= '0;
			version_q      <= '0;
			current_q      <= 1'b0;
			section_q      <= '0;
			last_section_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TABLE_ID:      table_id_q     <= cfg_data[7:0];
				REG_TABLE_ID_EXT:  table_ext_q    <= cfg_data;
				REG_VERSION:       version_q      <= cfg_data[4:0];
				REG_CURRENT_NEXT:  current_q      <= cfg_data[0];
				REG_SECTION_INDEX: section_q      <= cfg_data[7:0];
				REG_LAST_SECTION:  last_section_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Decode of the item held in the stage
	always_comb begin
		is_start  = (req_s1 == REQ_START);
		slen      = {1'b0, plen_s1} + HeaderTail;
		too_long  = slen > MaxSectionLength;
		rem_dec   = remaining_q - {{(LenW-1){1'b0}}, 1'b1};
		step_dec  = step_q - {{(StepW-1){1'b0}}, 1'b1};
		drop      = !is_start && (step_q == '0) && !open_q;
		slot_free = !out_valid_q || m_tready;
		advance   = valid_s1 && (drop || slot_free);
		emit      = valid_s1 && !drop && slot_free;

		// CRC bytes follow an empty start's header and a section's last payload byte.
		crc_phase = is_start ? step_q[3] : (step_q != '0);
		crc_sel   = is_start ? step_q[1:0] : step_dec[1:0];

		if (is_start) begin
			if (too_long) begin
				final_step = 1'b1;
			end else if (plen_s1 == '0) begin
				final_step = (step_q == StartLastStep);
			end else begin
				final_step = (step_q == HeaderLastStep);
			end
		end else if (drop) begin
			final_step = 1'b1;
		end else if (step_q == '0) begin
			final_step = (rem_dec != '0);
		end else begin
			final_step = (step_q == DataLastStep);
		end
	end

	// Header byte selection
	always_comb begin
		case (step_q[2:0])
			3'd0:    hdr_byte = table_id_q;
			3'd1:    hdr_byte = {SectionSyntaxNib, 2'b00, slen[9:8] & LengthHighMask};
			3'd2:    hdr_byte = slen[7:0];
			3'd3:    hdr_byte = table_ext_q[15:8];
			3'd4:    hdr_byte = table_ext_q[7:0];
			3'd5:    hdr_byte = {ReservedBits, version_q, current_q};
			3'd6:    hdr_byte = section_q;
			3'd7:    hdr_byte = last_section_q;
			default: hdr_byte = table_id_q;
		endcase
	end

	// Result byte: error, CRC, header or payload
	always_comb begin
		if (is_start && too_long) begin
			res_byte = 8'h00;
		end else if (crc_phase) begin
			case (crc_sel)
				2'd0:    res_byte = crc_q[31:24];
				2'd1:    res_byte = crc_q[23:16];
				2'd2:    res_byte = crc_q[15:8];
				2'd3:    res_byte = crc_q[7:0];
				default: res_byte = crc_q[31:24];
			endcase
		end else if (is_start) begin
			res_byte = hdr_byte;
		end else begin
			res_byte = data_s1;
		end
		crc_base = (is_start && (step_q == '0)) ? CrcInit : crc_q;
	end

	psf_crc_step u_crc (
		.crc_in  (crc_base),
		.byte_in (res_byte),
		.crc_out (crc_next)
	);

	// The stage takes a new item when it is empty or its item finishes this cycle.
	assign s_tready = !valid_s1 || (advance && final_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_q   <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance && final_step) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				step_q <= final_step ? '0 : step_q + {{(StepW-1){1'b0}}, 1'b1};
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= req_t'(s_tuser);
			plen_s1 <= s_tdata[9:0];
			data_s1 <= s_tdata[17:10];
		end
	end

	// Section state follows every emitted result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CrcInit;
			remaining_q <= '0;
			open_q      <= 1'b0;
		end else if (emit) begin
			if (is_start && too_long) begin
				crc_q       <= CrcInit;
				remaining_q <= '0;
				open_q      <= 1'b0;
			end else if (crc_phase) begin
				if (final_step) begin
					crc_q <= CrcInit;
				end
			end else if (is_start) begin
				crc_q <= crc_next;
				if (step_q == '0) begin
					open_q <= 1'b0;
				end
				if (step_q == HeaderLastStep) begin
					remaining_q <= plen_s1;
					open_q      <= (plen_s1 != '0);
				end
			end else begin
				crc_q       <= crc_next;
				remaining_q <= rem_dec;
				if (rem_dec == '0) begin
					open_q <= 1'b0;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= res_byte;
			out_last_q <= final_step;
			out_err_q  <= is_start && too_long;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	// An open section always has payload bytes left to take.
	`PSF_ASSERT_IMPL(a_open_has_bytes, open_q, remaining_q != '0, "open section with no bytes left")
	// The step counter stays within the longest item.
	`PSF_ASSERT_IMPL(a_step_range, valid_s1, step_q <= StartLastStep, "step counter out of range")
	// A full stage only takes a new item when its item finishes.
	`PSF_ASSERT_IMPL(a_stage_handoff, valid_s1 && s_tready, advance && final_step,
		"stage reloaded before its item finished")
	// An error result is a lone zero byte that ends its run.
	`PSF_ASSERT_IMPL(a_error_result, out_valid_q && out_err_q, out_last_q && (out_byte_q == 8'h00),
		"malformed length error result")

endmodule
